// ===== design/ils_pkg.sv =====
// shared types and constants of the indexed list store
`timescale 1ns / 1ps

package ils_pkg;

  // default list capacity
  localparam int ILS_CAPACITY = 256;

  // field widths
  localparam int ILS_WORD_W  = 32;
  localparam int ILS_POS_W   = 8;
  localparam int ILS_IDX_W   = 9;
  localparam int ILS_IN_W    = 56;
  localparam int ILS_OUT_W   = 56;

  // found index when the value is absent
  localparam logic signed [ILS_IDX_W-1:0] ILS_NOT_FOUND = '1;

  // operation codes
  typedef enum logic [2:0] {
    OP_APPEND       = 3'd0,
    OP_INSERT       = 3'd1,
    OP_REMOVE_AT    = 3'd2,
    OP_READ         = 3'd3,
    OP_WRITE        = 3'd4,
    OP_SWAP         = 3'd5,
    OP_FIND_LAST    = 3'd6,
    OP_REMOVE_VALUE = 3'd7
  } ils_op_t;

  // sequencer states
  typedef enum logic [9:0] {
    S_IDLE     = 10'b00_0000_0001,
    S_READ     = 10'b00_0000_0010,
    S_SHIFT_UP = 10'b00_0000_0100,
    S_PUT      = 10'b00_0000_1000,
    S_SHIFT_DN = 10'b00_0001_0000,
    S_SWAP_A   = 10'b00_0010_0000,
    S_SWAP_B   = 10'b00_0100_0000,
    S_SWAP_W   = 10'b00_1000_0000,
    S_FIND     = 10'b01_0000_0000,
    S_DONE     = 10'b10_0000_0000
  } ils_state_t;

  // finished result handed from the sequencer to the output register
  typedef struct packed {
    logic                        valid;
    logic                        ok;
    logic signed [ILS_WORD_W-1:0] read_value;
    logic signed [ILS_IDX_W-1:0]  found_index;
    logic [ILS_IDX_W-1:0]         entry_count;
  } ils_res_t;

endpackage

// ===== design/ils_ram.sv =====
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps

module ils_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/ils_ctrl.sv =====
// sequencer that walks the list one entry per cycle through the ram ports
`timescale 1ns / 1ps

module ils_ctrl import ils_pkg::*; #(
  parameter int CAPACITY = ILS_CAPACITY,
  localparam int ADDR_W = $clog2(CAPACITY),
  localparam int CNT_W  = $clog2(CAPACITY + 1)
) (
  input  logic                         clk,
  input  logic                         rst,
  // request word
  input  logic                         req_valid,
  output logic                         req_ready,
  input  ils_op_t                      req_op,
  input  logic [ILS_POS_W-1:0]         req_pos,
  input  logic [ILS_POS_W-1:0]         req_pos2,
  input  logic signed [ILS_WORD_W-1:0] req_word,
  // result
  input  logic                         out_free,
  output ils_res_t                     res,
  // ram ports
  output logic                         mem_wr_en,
  output logic [ADDR_W-1:0]            mem_wr_addr,
  output logic [ILS_WORD_W-1:0]        mem_wr_data,
  output logic                         mem_rd_en,
  output logic [ADDR_W-1:0]            mem_rd_addr,
  input  logic [ILS_WORD_W-1:0]        mem_rd_data
);

  localparam int CMP_W = ((CNT_W > ILS_POS_W) ? CNT_W : ILS_POS_W) + 1;

  ils_state_t                  state, state_next;
  logic [CNT_W-1:0]            cnt, cnt_next;
  logic [CNT_W-1:0]            idx, idx_next;
  ils_op_t                     op_r;
  logic [ILS_POS_W-1:0]        pos_r, pos2_r;
  logic [ILS_WORD_W-1:0]       word_r;
  logic [ILS_WORD_W-1:0]       tmp, tmp_next;
  logic                        ok, ok_next;
  logic signed [ILS_WORD_W-1:0] rd_val, rd_val_next;
  logic signed [ILS_IDX_W-1:0] found, found_next;

  logic take;
  logic pos_ok, pos2_ok, not_full, match;

  assign req_ready = (state == S_IDLE);
  assign take      = req_valid && req_ready;

  // range checks against the current fill count
  assign pos_ok   = CMP_W'(req_pos) < CMP_W'(cnt);
  assign pos2_ok  = CMP_W'(req_pos2) < CMP_W'(cnt);
  assign not_full = CMP_W'(cnt) < CMP_W'(CAPACITY);
  assign match    = (mem_rd_data == word_r);

  // next state and ram port control
  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    idx_next    = idx;
    tmp_next    = tmp;
    ok_next     = ok;
    rd_val_next = rd_val;
    found_next  = found;
    mem_wr_en   = 1'b0;
    mem_wr_addr = '0;
    mem_wr_data = mem_rd_data;
    mem_rd_en   = 1'b0;
    mem_rd_addr = '0;
    res         = '0;

    unique case (state)
      S_IDLE: begin
        if (take) begin
          ok_next     = 1'b0;
          rd_val_next = '0;
          found_next  = ILS_NOT_FOUND;
          state_next  = S_DONE;
          unique case (req_op)
            OP_APPEND: begin
              if (not_full) begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = ADDR_W'(cnt);
                mem_wr_data = req_word;
                cnt_next    = cnt + CNT_W'(1);
                ok_next     = 1'b1;
              end
            end
            OP_INSERT: begin
              if (pos_ok && not_full) begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = ADDR_W'(cnt - CNT_W'(1));
                idx_next    = cnt;
                state_next  = S_SHIFT_UP;
              end
            end
            OP_REMOVE_AT: begin
              if (pos_ok) begin
                if (CMP_W'(req_pos) + CMP_W'(1) == CMP_W'(cnt)) begin
                  cnt_next = cnt - CNT_W'(1);
                  ok_next  = 1'b1;
                end else begin
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = ADDR_W'(CMP_W'(req_pos) + CMP_W'(1));
                  idx_next    = CNT_W'(req_pos);
                  state_next  = S_SHIFT_DN;
                end
              end
            end
            OP_READ: begin
              if (pos_ok) begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = ADDR_W'(req_pos);
                state_next  = S_READ;
              end
            end
            OP_WRITE: begin
              if (pos_ok) begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = ADDR_W'(req_pos);
                mem_wr_data = req_word;
                ok_next     = 1'b1;
              end
            end
            OP_SWAP: begin
              if (pos_ok && pos2_ok) begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = ADDR_W'(req_pos);
                state_next  = S_SWAP_A;
              end
            end
            OP_FIND_LAST, OP_REMOVE_VALUE: begin
              if (cnt != '0) begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = ADDR_W'(cnt - CNT_W'(1));
                idx_next    = cnt - CNT_W'(1);
                state_next  = S_FIND;
              end
            end
            default: begin
              state_next = S_DONE;
            end
          endcase
        end
      end
      S_READ: begin
        rd_val_next = mem_rd_data;
        ok_next     = 1'b1;
        state_next  = S_DONE;
      end
      // move entry idx-1 up to idx, walking down to the insert point
      S_SHIFT_UP: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = ADDR_W'(idx);
        if (CMP_W'(idx) == CMP_W'(pos_r) + CMP_W'(1)) begin
          state_next = S_PUT;
        end else begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = ADDR_W'(idx - CNT_W'(2));
          idx_next    = idx - CNT_W'(1);
        end
      end
      S_PUT: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = ADDR_W'(pos_r);
        mem_wr_data = word_r;
        cnt_next    = cnt + CNT_W'(1);
        ok_next     = 1'b1;
        state_next  = S_DONE;
      end
      // move entry idx+1 down to idx, walking up to the end
      S_SHIFT_DN: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = ADDR_W'(idx);
        if (CMP_W'(idx) + CMP_W'(2) == CMP_W'(cnt)) begin
          cnt_next   = cnt - CNT_W'(1);
          ok_next    = 1'b1;
          state_next = S_DONE;
        end else begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = ADDR_W'(idx + CNT_W'(2));
          idx_next    = idx + CNT_W'(1);
        end
      end
      S_SWAP_A: begin
        tmp_next    = mem_rd_data;
        mem_rd_en   = 1'b1;
        mem_rd_addr = ADDR_W'(pos2_r);
        state_next  = S_SWAP_B;
      end
      S_SWAP_B: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = ADDR_W'(pos_r);
        state_next  = S_SWAP_W;
      end
      S_SWAP_W: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = ADDR_W'(pos2_r);
        mem_wr_data = tmp;
        ok_next     = 1'b1;
        state_next  = S_DONE;
      end
      // scan from the top down for the value
      S_FIND: begin
        if (match) begin
          found_next = ILS_IDX_W'(idx);
          ok_next    = 1'b1;
          state_next = S_DONE;
          if (op_r == OP_REMOVE_VALUE) begin
            if (CMP_W'(idx) + CMP_W'(1) == CMP_W'(cnt)) begin
              cnt_next = cnt - CNT_W'(1);
            end else begin
              mem_rd_en   = 1'b1;
              mem_rd_addr = ADDR_W'(idx + CNT_W'(1));
              state_next  = S_SHIFT_DN;
            end
          end
        end else if (idx == '0) begin
          state_next = S_DONE;
        end else begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = ADDR_W'(idx - CNT_W'(1));
          idx_next    = idx - CNT_W'(1);
        end
      end
      S_DONE: begin
        if (out_free) begin
          res.valid       = 1'b1;
          res.ok          = ok;
          res.read_value  = rd_val;
          res.found_index = found;
          res.entry_count = ILS_IDX_W'(cnt);
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // request capture and working registers
  always_ff @(posedge clk) begin
    if (take) begin
      op_r   <= req_op;
      pos_r  <= req_pos;
      pos2_r <= req_pos2;
      word_r <= req_word;
    end
    idx    <= idx_next;
    tmp    <= tmp_next;
    ok     <= ok_next;
    rd_val <= rd_val_next;
    found  <= found_next;
  end

endmodule

// ===== design/indexed_list_store.sv =====
// top level of the indexed list store: stream ports, output register, ram
`timescale 1ns / 1ps

// Ordered list of up to CAPACITY signed 32-bit entries held in one ram with a
// single write and a single registered read port. Each request word carries an
// operation and yields exactly one result word. The sequencer moves at most
// one entry per cycle through the ram ports, so the time per request follows
// from how many entries it touches: insert at position p shifts the entries
// from p up, remove at p shifts the entries above p down, find last scans
// down from the top, and remove value does the scan plus the shift down; the
// longest request is removing a value held only at index 0 of a full list,
// plus any wait on m_tready. s_tready is high only between requests. The
// finished result sits in an output register, so a new request is taken
// while the previous result still waits for m_tready. Entries need no
// clearing after reset; the list starts empty.
module indexed_list_store import ils_pkg::*; #(
  parameter int CAPACITY = ILS_CAPACITY
) (
  input  logic                 clk,
  input  logic                 rst,
  // request: operation[2:0], position[10:3], second_position[18:11],
  // value[50:19], zero fill above
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [ILS_IN_W-1:0]  s_tdata,
  // result: ok[0], read_value[32:1], found_index[41:33], entry_count[50:42],
  // zero fill above
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [ILS_OUT_W-1:0] m_tdata
);

  localparam int ADDR_W = $clog2(CAPACITY);

  ils_res_t                 res;
  logic                     out_free;
  logic                     mem_wr_en, mem_rd_en;
  logic [ADDR_W-1:0]        mem_wr_addr, mem_rd_addr;
  logic [ILS_WORD_W-1:0]    mem_wr_data, mem_rd_data;

  assign out_free = !m_tvalid || m_tready;

  // sequencer
  ils_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (s_tvalid),
    .req_ready   (s_tready),
    .req_op      (ils_op_t'(s_tdata[2:0])),
    .req_pos     (s_tdata[10:3]),
    .req_pos2    (s_tdata[18:11]),
    .req_word    (s_tdata[50:19]),
    .out_free    (out_free),
    .res         (res),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

  // entry storage
  ils_ram #(
    .WIDTH (ILS_WORD_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // output word valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res.valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // output word payload
  always_ff @(posedge clk) begin
    if (res.valid) begin
      m_tdata <= {{(ILS_OUT_W - 51){1'b0}}, res.entry_count, res.found_index,
                  res.read_value, res.ok};
    end
  end

  // a result is only pushed into a free output register
  a_push_free: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> out_free)
    else $error("result pushed into a full output register");

  // one request at a time: not ready right after taking one
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request taken while previous one still in progress");

  // results only leave the sequencer while it holds a request
  a_res_busy: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> !s_tready)
    else $error("result produced while idle");

  // a failed request reports a zero read value
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[0]) |-> (m_tdata[32:1] == '0))
    else $error("failed request with nonzero read value");

endmodule
